@@ rtl/kscm_pkg.sv @@
// shared types, constants and character table for the keypad scan core
package kscm_pkg;

    localparam int DATA_W = 8;
    localparam int KEY_W  = 4;
    localparam int SCAN_W = 16;

    // configuration register indexes
    localparam logic CFG_REPEAT_DELAY  = 1'b0;
    localparam logic CFG_REPEAT_REWIND = 1'b1;

    localparam logic [7:0] REPEAT_DELAY_RESET  = 8'd100;
    localparam logic [7:0] REPEAT_REWIND_RESET = 8'd33;

    localparam logic [4:0] KEY_NONE      = 5'd31;
    localparam logic [3:0] KEY_BACKSPACE = 4'd12;
    localparam logic [3:0] KEY_NEWLINE   = 4'd14;
    localparam logic [2:0] PAGE_NONE     = 3'd0;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    typedef struct packed {
        logic             found;
        logic [KEY_W-1:0] key;
    } key_info_t;

    typedef struct packed {
        logic              emit;
        logic [DATA_W-1:0] char_code;
        logic [KEY_W-1:0]  key_index;
    } key_result_t;

    // page is 0..3, key any non-page key
    function automatic logic [7:0] char_lookup(input logic [1:0] page, input logic [3:0] key);
        logic [3:0] idx;
        logic [7:0] base;
        logic [7:0] ch;
        idx = {key[3:2], 1'b0} + {2'b00, key[3:2]} + {2'b00, key[1:0]};
        unique case (page)
            2'd0:    base = 8'h41;  // 'A'
            2'd1:    base = 8'h4A;  // 'J'
            2'd2:    base = 8'h53;  // 'S'
            default: base = 8'h31;  // '1'
        endcase
        if (key[1:0] == 2'b11) begin
            ch = CHAR_SPACE;
        end
        else if (key[3:2] == 2'b11) begin
            unique case (key[1:0])
                2'd0:    ch = CHAR_BS;
                2'd1:    ch = (page == 2'd3) ? 8'h30 : CHAR_SPACE;
                default: ch = CHAR_LF;
            endcase
        end
        else if (page == 2'd2 && idx == 4'd8) begin
            // letter page runs out after 'Z'
            ch = CHAR_SPACE;
        end
        else begin
            ch = base + {4'd0, idx};
        end
        return ch;
    endfunction

endpackage

@@ rtl/kscm_key_decode.sv @@
// scan word to key number decode
module kscm_key_decode (
    input  logic [kscm_pkg::SCAN_W-1:0] scan,
    output kscm_pkg::key_info_t         info
);

    always_comb
    begin
        logic [3:0] nib;
        logic [3:0] cols;
        logic [1:0] row;
        logic       found;
        logic [1:0] col;
        cols  = 4'd0;
        row   = 2'd0;
        found = 1'b0;
        for (int r = 0; r < 4; r++)
        begin
            nib = ~scan[4*r +: 4];
            if (nib != 4'd0)
            begin
                found = 1'b1;
                row   = 2'(r);
                cols  = nib;
            end
        end
        // several columns low: column adds nothing
        unique case (cols)
            4'b0010: col = 2'd1;
            4'b0100: col = 2'd2;
            4'b1000: col = 2'd3;
            default: col = 2'd0;
        endcase
        info.found = found;
        info.key   = {row, col};
    end

endmodule

@@ rtl/kscm_key_ctrl.sv @@
// key state: hold counter, repeat, page select and character emit
module kscm_key_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  kscm_pkg::key_info_t   info,
    input  logic [7:0]            repeat_delay,
    input  logic [7:0]            repeat_rewind,
    output kscm_pkg::key_result_t result
);

    logic [4:0] prev_key_reg, prev_key_next;
    logic [7:0] hold_count_reg, hold_count_next;
    logic [2:0] page_mode_reg, page_mode_next;
    logic [4:0] last_key_reg, last_key_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_key_reg   <= kscm_pkg::KEY_NONE;
            hold_count_reg <= 8'd0;
            page_mode_reg  <= kscm_pkg::PAGE_NONE;
            last_key_reg   <= kscm_pkg::KEY_NONE;
        end
        else if (advance)
        begin
            prev_key_reg   <= prev_key_next;
            hold_count_reg <= hold_count_next;
            page_mode_reg  <= page_mode_next;
            last_key_reg   <= last_key_next;
        end
    end

    always_comb
    begin
        logic       act;
        logic [7:0] hold_inc;
        logic [4:0] key5;
        logic [2:0] page_m1;
        key5            = {1'b0, info.key};
        hold_inc        = hold_count_reg + 8'd1;
        page_m1         = page_mode_reg - 3'd1;
        act             = 1'b0;
        prev_key_next   = prev_key_reg;
        hold_count_next = hold_count_reg;
        page_mode_next  = page_mode_reg;
        last_key_next   = last_key_reg;
        result.emit      = 1'b0;
        result.key_index = info.key;
        result.char_code = kscm_pkg::char_lookup(page_m1[1:0], info.key);

        if (!info.found)
        begin
            prev_key_next = kscm_pkg::KEY_NONE;
        end
        else if (key5 != prev_key_reg)
        begin
            prev_key_next   = key5;
            hold_count_next = 8'd0;
            act             = 1'b1;
        end
        else if (hold_inc == repeat_delay)
        begin
            hold_count_next = hold_inc - repeat_rewind;
            act             = 1'b1;
        end
        else
        begin
            hold_count_next = hold_inc;
        end

        if (act)
        begin
            if (info.key[1:0] == 2'b11)
            begin
                // page key
                page_mode_next = {1'b0, info.key[3:2]} + 3'd1;
                last_key_next  = key5;
            end
            else if (last_key_reg != key5)
            begin
                if (info.key != kscm_pkg::KEY_BACKSPACE && info.key != kscm_pkg::KEY_NEWLINE)
                begin
                    last_key_next = key5;
                end
                result.emit = (page_mode_reg != kscm_pkg::PAGE_NONE);
            end
        end
    end

endmodule

@@ rtl/keypad_scan_repeat_char_map_core.sv @@
// top level: 4x4 keypad scan decode with auto-repeat and paged character output
// a scan item is held in the input register, its result item in the output register
// one item per cycle unless output stalls; input and result registers part the sides
// an item that produces no character still passes through the key state logic
// reset (async, active low): no key held, hold count 0, no page, delay 100, rewind 33
// nothing is emitted until one of the page keys (3, 7, 11, 15) has been pressed
module keypad_scan_repeat_char_map_core (
    input  logic                        clk,
    input  logic                        rst_n,
    // scan input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [kscm_pkg::SCAN_W-1:0] scan_cols,
    // character output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [kscm_pkg::DATA_W-1:0] char_code,
    output logic [kscm_pkg::KEY_W-1:0]  key_index,
    // configuration write port
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [7:0]                  cfg_data
);

    // configuration registers
    logic [7:0] repeat_delay_reg;
    logic [7:0] repeat_rewind_reg;

    // input stage
    logic                        s1_valid_reg, s1_valid_next;
    logic [kscm_pkg::SCAN_W-1:0] scan_reg;

    // output stage
    logic                        out_valid_reg, out_valid_next;
    logic [kscm_pkg::DATA_W-1:0] char_code_reg;
    logic [kscm_pkg::KEY_W-1:0]  key_index_reg;

    logic                  in_accept;
    logic                  out_free;
    logic                  advance;
    kscm_pkg::key_info_t   info;
    kscm_pkg::key_result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_delay_reg  <= kscm_pkg::REPEAT_DELAY_RESET;
            repeat_rewind_reg <= kscm_pkg::REPEAT_REWIND_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kscm_pkg::CFG_REPEAT_DELAY:  repeat_delay_reg  <= cfg_data;
                kscm_pkg::CFG_REPEAT_REWIND: repeat_rewind_reg <= cfg_data;
                default:                     repeat_delay_reg  <= repeat_delay_reg;
            endcase
        end
    end

    // result register can take a new item when empty or being drained this cycle
    assign out_free  = !out_valid_reg || !out_stall;
    // the input item moves through the key logic as soon as the result side has room
    assign advance   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = advance && result.emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            scan_reg <= scan_cols;
        end
        if (advance && result.emit)
        begin
            char_code_reg <= result.char_code;
            key_index_reg <= result.key_index;
        end
    end

    kscm_key_decode u_decode (
        .scan (scan_reg),
        .info (info)
    );

    kscm_key_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .info          (info),
        .repeat_delay  (repeat_delay_reg),
        .repeat_rewind (repeat_rewind_reg),
        .result        (result)
    );

    assign out_valid = out_valid_reg;
    assign char_code = char_code_reg;
    assign key_index = key_index_reg;

    // a character produced by the key logic lands in the result register
    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.emit |=> out_valid_reg)
        else $error("emitted item lost");

    // page keys never produce an item
    a_no_page_key_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> key_index_reg[1:0] != 2'b11)
        else $error("page key produced an item");

    // a waiting scan item is kept while the result side is blocked
    a_scan_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(scan_reg))
        else $error("pending scan item dropped");

    // key logic only runs with the result side free
    a_advance_room: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> !(out_valid_reg && out_stall))
        else $error("advance into a full result register");

endmodule

@@ tb/keypad_scan_repeat_char_map_core_check.sv @@
// scoreboard for the keypad scan core: predicts characters from scans and checks the output
module keypad_scan_repeat_char_map_core_check (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [kscm_pkg::SCAN_W-1:0] scan_cols,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [kscm_pkg::DATA_W-1:0] char_code,
    input  logic [kscm_pkg::KEY_W-1:0]  key_index,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [7:0]                  cfg_data,
    output int                          mismatch_count,
    output int                          chars_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import kscm_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic [3:0] key;
    } typed_char_t;

    // predicted keypad state
    logic [7:0] delay_reg;
    logic [7:0] rewind_reg;
    logic [4:0] held_key;
    logic [7:0] hold_ticks;
    logic [2:0] page_sel;
    logic [4:0] last_key;

    typed_char_t expected_chars[$];
    typed_char_t want;

    // character pages, key 0 in the top byte
    function automatic logic [7:0] glyph(input logic [2:0] page, input logic [3:0] key);
        logic [127:0] chars;
        case (page)
            3'd1:    chars = 128'h41424320_44454620_47484920_08200A20;
            3'd2:    chars = 128'h4A4B4C20_4D4E4F20_50515220_08200A20;
            3'd3:    chars = 128'h53545520_56575820_595A2020_08200A20;
            default: chars = 128'h31323320_34353620_37383920_08300A20;
        endcase
        return chars[8*(15-key) +: 8];
    endfunction

    // last row with a low column wins; several low columns leave the column at 0
    function automatic logic [4:0] scan_key(input logic [15:0] s);
        logic [3:0] low;
        logic [4:0] k;
        k = KEY_NONE;
        for (int r = 0; r < 4; r++)
        begin
            low = ~s[4*r +: 4];
            if (low != 4'd0)
            begin
                case (low)
                    4'd2:    k = 5'(4*r + 1);
                    4'd4:    k = 5'(4*r + 2);
                    4'd8:    k = 5'(4*r + 3);
                    default: k = 5'(4*r);
                endcase
            end
        end
        return k;
    endfunction

    task automatic act_on_key(input logic [3:0] k);
        typed_char_t c;
        if (k[1:0] == 2'b11)
        begin
            page_sel = {1'b0, k[3:2]} + 3'd1;
            last_key = {1'b0, k};
        end
        else if (last_key != {1'b0, k})
        begin
            if (k != KEY_BACKSPACE && k != KEY_NEWLINE)
                last_key = {1'b0, k};
            if (page_sel != PAGE_NONE)
            begin
                c.ch  = glyph(page_sel, k);
                c.key = k;
                expected_chars.push_back(c);
            end
        end
    endtask

    task automatic take_scan(input logic [15:0] s);
        logic [4:0] k;
        k = scan_key(s);
        if (k == KEY_NONE)
            held_key = KEY_NONE;
        else if (k != held_key)
        begin
            held_key   = k;
            hold_ticks = 8'd0;
            act_on_key(k[3:0]);
        end
        else
        begin
            hold_ticks = hold_ticks + 8'd1;
            if (hold_ticks == delay_reg)
            begin
                act_on_key(k[3:0]);
                hold_ticks = hold_ticks - rewind_reg;
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg      = REPEAT_DELAY_RESET;
            rewind_reg     = REPEAT_REWIND_RESET;
            held_key       = KEY_NONE;
            hold_ticks     = 8'd0;
            page_sel       = PAGE_NONE;
            last_key       = KEY_NONE;
            mismatch_count = 0;
            expected_chars.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_REPEAT_DELAY)
                    delay_reg = cfg_data;
                else
                    rewind_reg = cfg_data;
            end
            if (in_valid && !in_stall)
                take_scan(scan_cols);
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch($sformatf("unexpected char %h key %0d", char_code, key_index));
                else
                begin
                    want = expected_chars.pop_front();
                    if (char_code !== want.ch)
                        report_mismatch($sformatf("char %h, predicted %h (key %0d)",
                                                  char_code, want.ch, want.key));
                    if (key_index !== want.key)
                        report_mismatch($sformatf("key %0d, predicted %0d",
                                                  key_index, want.key));
                end
            end
        end
        chars_pending = expected_chars.size();
    end

endmodule

@@ tb/keypad_scan_repeat_char_map_core_test.sv @@
// testbench top for the keypad scan core: scan stimulus, output stalls and the verdict
module keypad_scan_repeat_char_map_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kscm_pkg::*;

    // the limit covers the slowest run, roughly 1250 items plus the long hold
    localparam int RUN_LIMIT = 400000;
    localparam int LONG_HOLD = 200;
    localparam int PHASES    = 8;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [SCAN_W-1:0] scan_cols;
    logic              out_valid;
    logic              out_stall;
    logic [DATA_W-1:0] char_code;
    logic [KEY_W-1:0]  key_index;
    logic              cfg_we;
    logic              cfg_index;
    logic [7:0]        cfg_data;

    int mismatch_count;
    int chars_pending;
    int scans_sent;
    int run_cycles;

    // stretches with no idling on either side
    bit tx_steady;
    bit rx_steady;
    // asks the output side for one long hold-off
    bit rx_hold_req;

    keypad_scan_repeat_char_map_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .scan_cols (scan_cols),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .key_index (key_index),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    keypad_scan_repeat_char_map_core_check score (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .scan_cols      (scan_cols),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .char_code      (char_code),
        .key_index      (key_index),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .chars_pending  (chars_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // give up if the run hangs
    initial
    begin
        for (run_cycles = 0; run_cycles < RUN_LIMIT; run_cycles++)
            @(posedge clk);
        $display("end of test: mismatches");
        $finish;
    end

    // output side: a random stall, possibly none, before each item, and one long hold-off when asked
    initial
    begin
        int wait_n;
        int held;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                rx_steady = !rx_steady;
            if (rx_hold_req)
            begin
                // hold off long enough that the core fills and stalls its input
                rx_hold_req = 1'b0;
                out_stall <= 1'b1;
                for (held = 0; held < LONG_HOLD; held++)
                    @(posedge clk);
            end
            else
            begin
                wait_n = rx_steady ? 0 : $urandom_range(0, 16);
                if (wait_n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (wait_n) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    // offer one scan after a random gap; valid stays high into the next call
    task automatic send_scan(input logic [15:0] s);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        scan_cols <= s;
        do
            @(posedge clk);
        while (in_stall);
        scans_sent++;
    endtask

    // scan with key k down: rows above it released, rows below it random since they are shadowed
    // with several set, the row gets two or more low columns
    function automatic logic [15:0] key_scan(input logic [3:0] k, input bit several);
        logic [15:0] s;
        logic [3:0]  low;
        int          a;
        s = 16'($urandom);
        for (int r = 0; r < 4; r++)
        begin
            if (r > k[3:2])
                s[4*r +: 4] = 4'hF;
        end
        if (several)
        begin
            a   = $urandom_range(0, 3);
            low = (4'b0001 << a) | (4'b0001 << ((a + $urandom_range(1, 3)) % 4))
                  | 4'($urandom_range(0, 15));
        end
        else
            low = 4'b0001 << k[1:0];
        s[4*k[3:2] +: 4] = ~low;
        return s;
    endfunction

    // hold a key down for a number of scans
    task automatic press_key(input logic [3:0] k, input int ticks, input bit several);
        repeat (ticks) send_scan(key_scan(k, several));
    endtask

    // stop offering, wait for every predicted char, then let the key state settle
    task automatic drain_chars();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (chars_pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_repeat(input logic [7:0] delay_ticks, input logic [7:0] rewind_ticks);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_REPEAT_DELAY;
        cfg_data  <= delay_ticks;
        @(posedge clk);
        cfg_index <= CFG_REPEAT_REWIND;
        cfg_data  <= rewind_ticks;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly well-formed presses and holds with random shadow rows, some noise scans
    task automatic random_phase(input int n, input int reach);
        int         stop_at;
        int         ticks;
        logic [3:0] k;
        stop_at = scans_sent + n;
        while (scans_sent < stop_at)
        begin
            if ($urandom_range(0, 31) == 0)
                tx_steady = !tx_steady;
            case ($urandom_range(0, 9))
                0, 1:
                    send_scan(16'($urandom));
                2:
                    press_key({2'($urandom_range(0, 3)), 2'b00}, $urandom_range(1, 4), 1'b1);
                default:
                begin
                    // lean on backspace and newline, the only keys whose repeats show up
                    case ($urandom_range(0, 9))
                        0, 1, 2: k = $urandom_range(0, 1) ? KEY_BACKSPACE : KEY_NEWLINE;
                        3:       k = {2'($urandom_range(0, 3)), 2'b11};
                        default: k = 4'($urandom_range(0, 15));
                    endcase
                    ticks = ($urandom_range(0, 2) == 0) ? $urandom_range(1, reach)
                                                        : $urandom_range(1, 3);
                    press_key(k, ticks, 1'b0);
                    if ($urandom_range(0, 1))
                        send_scan(16'hFFFF);
                end
            endcase
        end
    endtask

    initial
    begin
        logic [7:0] delay_ticks;
        logic [7:0] rewind_ticks;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        scan_cols   <= 16'hFFFF;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_REPEAT_DELAY;
        cfg_data    <= 8'd0;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
        rx_hold_req = 1'b0;
        scans_sent  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset delay and rewind
        send_scan(16'hFFFF);            // nothing pressed
        send_scan(key_scan(4'd0, 1'b0)); // no page chosen yet, silent
        send_scan(16'hFFFF);
        send_scan(key_scan(4'd3, 1'b0)); // letter page A-I
        send_scan(key_scan(4'd0, 1'b0));
        send_scan(16'hFFFF);
        send_scan(key_scan(4'd0, 1'b0)); // same key acting again, suppressed
        send_scan(key_scan(4'd5, 1'b0));
        send_scan(key_scan(4'd8, 1'b1)); // several columns low, column ignored
        send_scan(key_scan(KEY_BACKSPACE, 1'b0));
        send_scan(16'hFFFF);
        send_scan(key_scan(KEY_BACKSPACE, 1'b0)); // backspace emits every time
        send_scan(key_scan(KEY_NEWLINE, 1'b0));
        send_scan(key_scan(4'd7, 1'b0)); // page J-R
        send_scan(key_scan(4'd13, 1'b0));
        send_scan(key_scan(4'd11, 1'b0)); // page S-Z, runs out of letters
        send_scan(key_scan(4'd9, 1'b0));
        send_scan(key_scan(4'd10, 1'b0));
        send_scan(key_scan(4'd15, 1'b0)); // digit page
        send_scan(key_scan(4'd13, 1'b0));
        send_scan(key_scan(4'd1, 1'b0));
        send_scan(16'h0000);             // every column low everywhere
        send_scan(16'h0FFF);             // same key still held
        send_scan(16'hFFF0);
        drain_chars();

        // extremes: shortest delay, no rewind; longest delay, full wrap; delay 1, rewind 255
        set_repeat(8'd1, 8'd0);
        press_key(KEY_NEWLINE, 12, 1'b0);
        drain_chars();
        set_repeat(8'd255, 8'd255);
        press_key(KEY_BACKSPACE, 300, 1'b0);
        drain_chars();
        set_repeat(8'd1, 8'd255);
        press_key(KEY_BACKSPACE, 6, 1'b0);
        drain_chars();

        for (int p = 0; p < PHASES; p++)
        begin
            // short delays mostly, so held keys repeat often
            delay_ticks  = (p % 4 == 3) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 12));
            rewind_ticks = (p % 2 == 1) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, delay_ticks));
            set_repeat(delay_ticks, rewind_ticks);
            if (p == 2)
            begin
                // output side goes quiet while scans keep coming back to back
                tx_steady   = 1'b1;
                rx_hold_req = 1'b1;
            end
            random_phase(110, (2 * delay_ticks + 4 > 60) ? 60 : 2 * delay_ticks + 4);
            drain_chars();
        end

        // everything predicted has arrived; give any stray item time to show
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && chars_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
